// ===== rtl/wels_pkg.sv =====
// ----------------------------------------------------------------------------
// wels_pkg
// Item types, command codes and status codes of the weighted edge list store.
// ----------------------------------------------------------------------------
`default_nettype none

package wels_pkg;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int VERTEX_W = 9;
    localparam int WEIGHT_W = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // reset value of the vertex count register
    localparam logic [VERTEX_W-1:0] NUM_VERTICES_RST = 9'd256;

    typedef struct packed {
        logic [CMD_W-1:0]           command;
        logic [VERTEX_W-1:0]        src_vertex;
        logic [VERTEX_W-1:0]        dst_vertex;
        logic signed [WEIGHT_W-1:0] edge_weight;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic signed [WEIGHT_W-1:0] found_weight;
        logic                       vertex_empty;
        logic [COUNT_W-1:0]         edges_stored;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/weighted_edge_list_store.sv =====
// ----------------------------------------------------------------------------
// weighted_edge_list_store
// Directed weighted graph kept as per-vertex linked lists in an edge RAM,
// with a head RAM and a free slot stack RAM.
// Insert, empty query and invalid vertex pass from accept through the head
// read and done states to the result register; lookup and remove also walk
// the list in between, one edge RAM read per cycle. One item at a time: the
// next item is taken once the last result is registered, later while a result
// waits downstream. Reset: a clearing pass fills the head RAM with null and the
// free stack with all slots; no item before.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_edge_list_store #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [wels_pkg::VERTEX_W-1:0]       cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire wels_pkg::in_item_t                  in_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output wels_pkg::out_item_t                      out_data
);

    import wels_pkg::*;

    // link width holds the null code MAX_EDGES, slot width indexes the edge RAM
    localparam int EW       = $clog2(MAX_EDGES + 1);
    localparam int SW       = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int HD       = MAX_VERTICES + 1;
    localparam int HW       = $clog2(HD);
    localparam int INIT_LEN = (HD > MAX_EDGES) ? HD : MAX_EDGES;
    localparam int IW       = (INIT_LEN > 1) ? $clog2(INIT_LEN) : 1;

    localparam logic [EW-1:0] NIL       = EW'(MAX_EDGES);
    localparam logic [IW-1:0] INIT_LAST = IW'(INIT_LEN - 1);

    // state codes
    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    typedef struct packed {
        logic [VERTEX_W-1:0]        dst;
        logic signed [WEIGHT_W-1:0] weight;
        logic [EW-1:0]              next;
    } edge_t;

    // control registers
    logic [2:0]          state_reg, state_next;
    logic [IW-1:0]       init_reg, init_next;
    logic [VERTEX_W-1:0] nv_reg;
    logic [EW-1:0]       free_count_reg, free_count_next;
    logic [EW-1:0]       count_reg, count_next;
    logic                out_valid_reg, out_valid_next;

    // payload registers
    in_item_t            item_reg, item_next;
    logic                ok_reg, ok_next;
    logic [SW-1:0]       cur_reg, cur_next;
    logic [EW-1:0]       prev_reg, prev_next;
    edge_t               prev_data_reg, prev_data_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [WEIGHT_W-1:0] res_weight_reg, res_weight_next;
    logic                res_empty_reg, res_empty_next;
    out_item_t           out_reg, out_next;

    // memory ports
    logic          head_we;
    logic [HW-1:0] head_waddr, head_raddr;
    logic [EW-1:0] head_wdata, head_rdata;
    logic          edge_we;
    logic [SW-1:0] edge_waddr, edge_raddr;
    edge_t         edge_wdata, edge_rdata;
    logic          free_we;
    logic [SW-1:0] free_waddr, free_raddr;
    logic [SW-1:0] free_wdata, free_rdata;

    logic src_ok, dst_ok;

    wels_ram #(.WIDTH(EW), .DEPTH(HD)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    wels_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    wels_ram #(.WIDTH(SW), .DEPTH(MAX_EDGES)) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    // vertex range checks on the incoming item
    assign src_ok = (in_data.src_vertex != '0) && (in_data.src_vertex <= nv_reg)
                    && (32'(in_data.src_vertex) <= MAX_VERTICES);
    assign dst_ok = (in_data.dst_vertex != '0) && (in_data.dst_vertex <= nv_reg)
                    && (32'(in_data.dst_vertex) <= MAX_VERTICES);

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // sequencer: read, compare, link and write back
    always_comb
    begin
        state_next      = state_reg;
        init_next       = init_reg;
        free_count_next = free_count_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        item_next       = item_reg;
        ok_next         = ok_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_data_next  = prev_data_reg;
        res_status_next = res_status_reg;
        res_weight_next = res_weight_reg;
        res_empty_next  = res_empty_reg;
        out_next        = out_reg;

        head_we    = 1'b0;
        head_waddr = HW'(item_reg.src_vertex);
        head_wdata = NIL;
        head_raddr = HW'(in_data.src_vertex);
        edge_we    = 1'b0;
        edge_waddr = free_rdata;
        edge_wdata = '{dst: item_reg.dst_vertex, weight: item_reg.edge_weight,
                       next: head_rdata};
        edge_raddr = SW'(head_rdata);
        free_we    = 1'b0;
        free_waddr = SW'(free_count_reg);
        free_wdata = cur_reg;
        free_raddr = SW'(free_count_reg - 1'b1);

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                head_we    = (32'(init_reg) < HD);
                head_waddr = HW'(init_reg);
                head_wdata = NIL;
                free_we    = (32'(init_reg) < MAX_EDGES);
                free_waddr = SW'(init_reg);
                free_wdata = SW'(init_reg);
                if (init_reg == INIT_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_next = init_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    ok_next    = src_ok && ((in_data.command == CMD_QUERY) || dst_ok);
                    state_next = S_HEAD;
                end
            end

            S_HEAD:
            begin
                res_status_next = ST_OK;
                res_weight_next = '0;
                res_empty_next  = 1'b0;
                state_next      = S_DONE;
                if (!ok_reg)
                begin
                    res_status_next = ST_INVALID;
                end
                else
                begin
                    case (item_reg.command)
                        CMD_QUERY:
                        begin
                            res_empty_next = (head_rdata == NIL);
                        end
                        CMD_INSERT:
                        begin
                            if (free_count_reg == '0)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                // push new edge at list head
                                edge_we         = 1'b1;
                                head_we         = 1'b1;
                                head_wdata      = EW'(free_rdata);
                                free_count_next = free_count_reg - 1'b1;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            if (head_rdata == NIL)
                            begin
                                res_status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                cur_next   = SW'(head_rdata);
                                prev_next  = NIL;
                                state_next = S_WALK;
                            end
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                if (edge_rdata.dst == item_reg.dst_vertex)
                begin
                    state_next = S_DONE;
                    if (item_reg.command == CMD_LOOKUP)
                    begin
                        res_weight_next = edge_rdata.weight;
                    end
                    else
                    begin
                        // unlink the match and return its slot
                        if (prev_reg == NIL)
                        begin
                            head_we    = 1'b1;
                            head_wdata = edge_rdata.next;
                        end
                        else
                        begin
                            edge_we    = 1'b1;
                            edge_waddr = SW'(prev_reg);
                            edge_wdata = '{dst: prev_data_reg.dst,
                                           weight: prev_data_reg.weight,
                                           next: edge_rdata.next};
                        end
                        free_we         = 1'b1;
                        free_count_next = free_count_reg + 1'b1;
                        count_next      = count_reg - 1'b1;
                    end
                end
                else if (edge_rdata.next == NIL)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    // step to the next list entry
                    prev_next      = EW'(cur_reg);
                    prev_data_next = edge_rdata;
                    cur_next       = SW'(edge_rdata.next);
                    edge_raddr     = SW'(edge_rdata.next);
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.status       = res_status_reg;
                    out_next.found_weight = res_weight_reg;
                    out_next.vertex_empty = res_empty_reg;
                    out_next.edges_stored = COUNT_W'(count_reg);
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
                init_next  = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            init_reg       <= '0;
            nv_reg         <= NUM_VERTICES_RST;
            free_count_reg <= EW'(MAX_EDGES);
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_reg       <= init_next;
            free_count_reg <= free_count_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                nv_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        ok_reg         <= ok_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        prev_data_reg  <= prev_data_next;
        res_status_reg <= res_status_next;
        res_weight_reg <= res_weight_next;
        res_empty_reg  <= res_empty_next;
        out_reg        <= out_next;
    end

`ifndef ASSERT_OFF
    // every slot is either free or linked into a list
    a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
        ((EW+1)'(free_count_reg) + (EW+1)'(count_reg)) == (EW+1)'(MAX_EDGES))
        else $error("free and stored edge counts do not add up");

    // stored edge count stays within the edge RAM
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_EDGES)
        else $error("edge count beyond capacity");

    // an accepted item goes to the head read
    a_accept_head: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_HEAD))
        else $error("accepted item did not start head read");

    // a list walk implies at least one stored edge
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (count_reg != '0))
        else $error("list walk with no stored edges");
`endif

endmodule

`default_nettype wire

// ===== rtl/wels_ram.sv =====
// ----------------------------------------------------------------------------
// wels_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module wels_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
